### rtl/first_fit_block_allocator_top_assert.svh
// Assertion macros for the allocator top level.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define FFBA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define FFBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FFBA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define FFBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/ffba_pkg.sv
package ffba_pkg;

  localparam int SIZE_W = 15;
  localparam int IDX_W  = 8;
  localparam int STAT_W = 2;
  localparam int USED_W = 15;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [STAT_W-1:0] ST_ZERO  = 2'd2;

  typedef logic [4:0] op_t;

  // Datapath operations
  localparam op_t OP_NOP        = 5'd0;
  localparam op_t OP_LATCH      = 5'd1;
  localparam op_t OP_ZERO       = 5'd2;
  localparam op_t OP_DIV        = 5'd3;
  localparam op_t OP_RD_ORD     = 5'd4;
  localparam op_t OP_RD_LEN_ORD = 5'd5;
  localparam op_t OP_CMP        = 5'd6;
  localparam op_t OP_NOFIT      = 5'd7;
  localparam op_t OP_SPLIT1     = 5'd8;
  localparam op_t OP_SPLIT2     = 5'd9;
  localparam op_t OP_GRANT      = 5'd10;
  localparam op_t OP_ADD        = 5'd11;
  localparam op_t OP_F_RDLEN    = 5'd12;
  localparam op_t OP_F_TAKE     = 5'd13;
  localparam op_t OP_F_NEIGH    = 5'd14;
  localparam op_t OP_F_NL       = 5'd15;
  localparam op_t OP_FIND_CMP   = 5'd16;
  localparam op_t OP_NX1        = 5'd17;
  localparam op_t OP_NX2        = 5'd18;
  localparam op_t OP_PV1        = 5'd19;
  localparam op_t OP_PV2        = 5'd20;
  localparam op_t OP_APPEND     = 5'd21;
  localparam op_t OP_DROP_INIT  = 5'd22;
  localparam op_t OP_DROP_RD    = 5'd23;
  localparam op_t OP_DROP_WR    = 5'd24;
  localparam op_t OP_DROP_END   = 5'd25;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic size_zero;
    logic idx_end;
    logic fit;
    logic exact;
    logic bad_free;
    logic bad_len;
    logic next_free;
    logic prev_free;
    logic merged;
    logic hit;
    logic drop_more;
    logic found;
  } stat_t;

endpackage

### rtl/ffba_datapath.sv
module ffba_datapath import ffba_pkg::*; #(
  parameter int UNITS      = 256,
  parameter int UNIT_BYTES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              kind,
  input  logic [SIZE_W-1:0] size_bytes,
  input  logic [IDX_W-1:0]  block_index,
  input  cmd_t              cmd,
  output stat_t             stat,
  output logic [STAT_W-1:0] status,
  output logic [IDX_W-1:0]  granted_index,
  output logic [USED_W-1:0] used_bytes_now
);

  localparam int IW    = $clog2(UNITS);
  localparam int CW    = $clog2(UNITS + 1);
  localparam int AW    = CW + 1;
  localparam int DW    = $clog2((1 << SIZE_W) + UNIT_BYTES);
  localparam int BW    = $clog2(UNIT_BYTES + 1);
  localparam int PW    = CW + BW;
  // Reciprocal of the unit size, exact for every dividend below 2^DW
  localparam int LG    = $clog2(UNIT_BYTES);
  localparam int SH    = DW + LG;
  localparam int RW    = DW + 1;
  localparam int MW    = DW + RW;
  localparam logic [RW-1:0] RECIP =
    RW'(((longint'(1) << SH) + longint'(UNIT_BYTES) - 1) / longint'(UNIT_BYTES));

  // Boundary tag stores
  logic [CW-1:0] len_mem  [UNITS];
  logic [IW-1:0] head_mem [UNITS];
  logic [IW-1:0] ord_mem  [UNITS];

  logic          len0_ok, head_last_ok, ord0_ok;
  logic [CW-1:0] len_q;
  logic [IW-1:0] head_q, ord_q;

  logic          len_we, len_re, head_we, head_re, ord_we, ord_re;
  logic [IW-1:0] len_wa, len_ra, head_wa, head_ra, ord_wa, ord_ra;
  logic [CW-1:0] len_wd;
  logic [IW-1:0] head_wd, ord_wd;

  // Per-unit flags
  logic [UNITS-1:0] is_free;
  logic [UNITS-1:0] gmark;

  // Working registers
  logic              kind_q, size_zero_q, idx_bad, merged, found;
  logic              next_free, prev_free;
  logic [IW-1:0]     h, p, tgt;
  logic [CW-1:0]     len, nl, idx, pos, total;
  logic [DW-1:0]     dvd, units;
  logic [PW-1:0]     prod;
  logic [STAT_W-1:0] status_q;
  logic [IDX_W-1:0]  granted_q;
  logic [USED_W-1:0] used;

  // Derived values
  logic [MW-1:0] qprod;
  logic [CW-1:0] units_c;
  logic [AW-1:0] h_w, rest_w, n_w, split_tail_w, run_tail_w, merge_tail_w;

  assign qprod        = MW'(dvd) * MW'(RECIP);
  assign units_c      = units[CW-1:0];
  assign h_w          = AW'(h);
  assign rest_w       = h_w + AW'(units_c);
  assign n_w          = h_w + AW'(len);
  assign split_tail_w = rest_w - AW'(1);
  assign run_tail_w   = n_w - AW'(1);
  assign merge_tail_w = n_w + AW'(nl) - AW'(1);

  // Status to the controller
  always_comb begin
    stat.kind      = kind_q;
    stat.size_zero = size_zero_q;
    stat.idx_end   = idx >= total;
    stat.fit       = DW'(len_q) >= units;
    stat.exact     = DW'(len_q) == units;
    stat.bad_free  = idx_bad || !gmark[h];
    stat.bad_len   = (len_q == '0) || (h_w + AW'(len_q) > AW'(UNITS));
    stat.next_free = next_free;
    stat.prev_free = prev_free;
    stat.merged    = merged;
    stat.hit       = ord_q == tgt;
    stat.drop_more = (AW'(idx) + AW'(1)) < AW'(total);
    stat.found     = found;
  end

  // Decode memory ports per operation
  always_comb begin
    len_we  = 1'b0; len_re  = 1'b0; len_wa  = h; len_ra  = h; len_wd  = len;
    head_we = 1'b0; head_re = 1'b0; head_wa = h; head_ra = h; head_wd = h;
    ord_we  = 1'b0; ord_re  = 1'b0; ord_wa  = pos[IW-1:0]; ord_ra = idx[IW-1:0]; ord_wd = h;
    case (cmd.op)
      OP_RD_ORD: begin
        ord_re = 1'b1;
      end
      OP_RD_LEN_ORD: begin
        len_re = 1'b1;
        len_ra = ord_q;
      end
      OP_SPLIT1: begin
        len_we  = 1'b1;
        len_wd  = units_c;
        head_we = 1'b1;
        head_wa = split_tail_w[IW-1:0];
        ord_we  = 1'b1;
        ord_wd  = rest_w[IW-1:0];
      end
      OP_SPLIT2: begin
        len_we  = 1'b1;
        len_wa  = rest_w[IW-1:0];
        len_wd  = len - units_c;
        head_we = 1'b1;
        head_wa = run_tail_w[IW-1:0];
        head_wd = rest_w[IW-1:0];
      end
      OP_F_RDLEN: begin
        len_re = 1'b1;
      end
      OP_F_TAKE: begin
        head_re = 1'b1;
        head_ra = h - IW'(1);
      end
      OP_F_NEIGH: begin
        len_re = 1'b1;
        len_ra = n_w[IW-1:0];
      end
      OP_NX1: begin
        ord_we  = found;
        head_we = 1'b1;
        head_wa = merge_tail_w[IW-1:0];
      end
      OP_NX2: begin
        len_we = 1'b1;
      end
      OP_PV1: begin
        len_re  = 1'b1;
        len_ra  = p;
        head_we = 1'b1;
        head_wa = run_tail_w[IW-1:0];
        head_wd = p;
      end
      OP_PV2: begin
        len_we = 1'b1;
        len_wa = p;
        len_wd = len_q + len;
      end
      OP_APPEND: begin
        ord_we = total < CW'(UNITS);
        ord_wa = total[IW-1:0];
      end
      OP_DROP_RD: begin
        ord_re = 1'b1;
        ord_ra = idx[IW-1:0] + IW'(1);
      end
      OP_DROP_WR: begin
        ord_we = 1'b1;
        ord_wa = idx[IW-1:0];
        ord_wd = ord_q;
      end
      default: begin
      end
    endcase
  end

  // Mark entries that hold their reset value until first written
  always_ff @(posedge clk) begin
    if (rst) begin
      len0_ok      <= 1'b0;
      head_last_ok <= 1'b0;
      ord0_ok      <= 1'b0;
    end else begin
      if (len_we && len_wa == '0) len0_ok <= 1'b1;
      if (head_we && head_wa == IW'(UNITS - 1)) head_last_ok <= 1'b1;
      if (ord_we && ord_wa == '0) ord0_ok <= 1'b1;
    end
  end

  // Run length store
  always_ff @(posedge clk) begin
    if (len_we) len_mem[len_wa] <= len_wd;
    if (len_re) len_q <= (!len0_ok && len_ra == '0) ? CW'(UNITS) : len_mem[len_ra];
  end

  // Run head store
  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (head_re) begin
      head_q <= (!head_last_ok && head_ra == IW'(UNITS - 1)) ? '0 : head_mem[head_ra];
    end
  end

  // Free list order store
  always_ff @(posedge clk) begin
    if (ord_we) ord_mem[ord_wa] <= ord_wd;
    if (ord_re) ord_q <= (!ord0_ok && ord_ra == '0) ? '0 : ord_mem[ord_ra];
  end

  // Control state and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      is_free   <= UNITS'(1);
      gmark     <= '0;
      total     <= CW'(1);
      used      <= '0;
      status_q  <= ST_OK;
      granted_q <= '0;
    end else begin
      case (cmd.op)
        OP_LATCH: begin
          status_q  <= ST_OK;
          granted_q <= '0;
        end
        OP_ZERO:     status_q <= ST_ZERO;
        OP_NOFIT:    status_q <= ST_NOFIT;
        OP_SPLIT1:   is_free[rest_w[IW-1:0]] <= 1'b1;
        OP_GRANT: begin
          is_free[h] <= 1'b0;
          gmark[h]   <= 1'b1;
          granted_q  <= IDX_W'(h);
        end
        OP_ADD:      used <= used + USED_W'(prod);
        OP_F_TAKE:   gmark[h] <= 1'b0;
        OP_F_NEIGH:  used <= used - USED_W'(prod);
        OP_NX1:      is_free[n_w[IW-1:0]] <= 1'b0;
        OP_NX2:      is_free[h] <= 1'b1;
        OP_PV2:      is_free[h] <= 1'b0;
        OP_APPEND: begin
          is_free[h] <= 1'b1;
          if (total < CW'(UNITS)) total <= total + CW'(1);
        end
        OP_DROP_END: total <= total - CW'(1);
        default: begin
        end
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        kind_q      <= kind;
        size_zero_q <= size_bytes == '0;
        idx_bad     <= 32'(block_index) >= UNITS;
        h           <= IW'(block_index);
        dvd         <= DW'(size_bytes) + DW'(UNIT_BYTES - 1);
        units       <= '0;
        idx         <= '0;
        merged      <= 1'b0;
        found       <= 1'b0;
      end
      // Round up to whole units by reciprocal multiplication
      OP_DIV:    units <= DW'(qprod >> SH);
      OP_RD_LEN_ORD: h <= ord_q;
      OP_CMP: begin
        len   <= len_q;
        pos   <= idx;
        found <= 1'b1;
        if (!stat.fit) idx <= idx + CW'(1);
      end
      OP_GRANT:  prod <= PW'(units_c) * PW'(UNIT_BYTES);
      OP_F_TAKE: begin
        len  <= len_q;
        prod <= PW'(len_q) * PW'(UNIT_BYTES);
      end
      OP_F_NEIGH: begin
        next_free <= (n_w < AW'(UNITS)) && is_free[n_w[IW-1:0]];
        p         <= head_q;
        prev_free <= (h != '0) && (head_q < h) && is_free[head_q];
      end
      OP_F_NL: begin
        nl    <= len_q;
        tgt   <= n_w[IW-1:0];
        idx   <= '0;
        found <= 1'b0;
      end
      OP_FIND_CMP: begin
        if (stat.hit) begin
          found <= 1'b1;
          pos   <= idx;
        end else begin
          idx <= idx + CW'(1);
        end
      end
      OP_NX1: begin
        len    <= len + nl;
        merged <= 1'b1;
      end
      OP_PV2: begin
        tgt   <= h;
        idx   <= '0;
        found <= 1'b0;
      end
      OP_DROP_INIT: idx <= pos;
      OP_DROP_WR:   idx <= idx + CW'(1);
      default: begin
      end
    endcase
  end

  assign status         = status_q;
  assign granted_index  = granted_q;
  assign used_bytes_now = used;

endmodule

### rtl/ffba_ctrl.sv
module ffba_ctrl import ffba_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  done
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DISP    = 5'd1;
  localparam logic [4:0] S_DIV     = 5'd2;
  localparam logic [4:0] S_AS_RD   = 5'd3;
  localparam logic [4:0] S_AS_LEN  = 5'd4;
  localparam logic [4:0] S_AS_CMP  = 5'd5;
  localparam logic [4:0] S_SPLIT1  = 5'd6;
  localparam logic [4:0] S_SPLIT2  = 5'd7;
  localparam logic [4:0] S_GRANT   = 5'd8;
  localparam logic [4:0] S_ADD     = 5'd9;
  localparam logic [4:0] S_F_RD    = 5'd10;
  localparam logic [4:0] S_F_CHK   = 5'd11;
  localparam logic [4:0] S_F_NEIGH = 5'd12;
  localparam logic [4:0] S_F_NL    = 5'd13;
  localparam logic [4:0] S_FD_RD   = 5'd14;
  localparam logic [4:0] S_FD_CMP  = 5'd15;
  localparam logic [4:0] S_NX1     = 5'd16;
  localparam logic [4:0] S_NX2     = 5'd17;
  localparam logic [4:0] S_PV_CHK  = 5'd18;
  localparam logic [4:0] S_PV1     = 5'd19;
  localparam logic [4:0] S_PV2     = 5'd20;
  localparam logic [4:0] S_APPEND  = 5'd21;
  localparam logic [4:0] S_DR_INIT = 5'd22;
  localparam logic [4:0] S_DR_CHK  = 5'd23;
  localparam logic [4:0] S_DR_WR   = 5'd24;
  localparam logic [4:0] S_DONE    = 5'd25;

  logic [4:0] state, state_next;
  // set while the list search looks for the freed head to drop it
  logic       ret, ret_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= 1'b0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  // Sequence the datapath
  always_comb begin
    state_next = state;
    ret_next   = ret;
    cmd.op     = OP_NOP;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op     = OP_LATCH;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.kind) begin
          state_next = S_F_RD;
        end else if (stat.size_zero) begin
          cmd.op     = OP_ZERO;
          state_next = S_DONE;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.op     = OP_DIV;
        state_next = S_AS_RD;
      end
      S_AS_RD: begin
        if (stat.idx_end) begin
          cmd.op     = OP_NOFIT;
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_RD_ORD;
          state_next = S_AS_LEN;
        end
      end
      S_AS_LEN: begin
        cmd.op     = OP_RD_LEN_ORD;
        state_next = S_AS_CMP;
      end
      S_AS_CMP: begin
        cmd.op = OP_CMP;
        if (!stat.fit) state_next = S_AS_RD;
        else if (stat.exact) state_next = S_DR_INIT;
        else state_next = S_SPLIT1;
      end
      S_SPLIT1: begin
        cmd.op     = OP_SPLIT1;
        state_next = S_SPLIT2;
      end
      S_SPLIT2: begin
        cmd.op     = OP_SPLIT2;
        state_next = S_GRANT;
      end
      S_GRANT: begin
        cmd.op     = OP_GRANT;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.op     = OP_ADD;
        state_next = S_DONE;
      end
      S_F_RD: begin
        cmd.op     = OP_F_RDLEN;
        state_next = stat.bad_free ? S_DONE : S_F_CHK;
      end
      S_F_CHK: begin
        if (stat.bad_len) begin
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_F_TAKE;
          state_next = S_F_NEIGH;
        end
      end
      S_F_NEIGH: begin
        cmd.op     = OP_F_NEIGH;
        state_next = S_F_NL;
      end
      S_F_NL: begin
        cmd.op     = OP_F_NL;
        ret_next   = 1'b0;
        state_next = stat.next_free ? S_FD_RD : S_PV_CHK;
      end
      S_FD_RD: begin
        if (stat.idx_end) begin
          state_next = ret ? S_DONE : S_NX1;
        end else begin
          cmd.op     = OP_RD_ORD;
          state_next = S_FD_CMP;
        end
      end
      S_FD_CMP: begin
        cmd.op = OP_FIND_CMP;
        if (stat.hit) state_next = ret ? S_DR_INIT : S_NX1;
        else state_next = S_FD_RD;
      end
      S_NX1: begin
        cmd.op     = OP_NX1;
        state_next = S_NX2;
      end
      S_NX2: begin
        cmd.op     = OP_NX2;
        state_next = S_PV_CHK;
      end
      S_PV_CHK: begin
        if (stat.prev_free) state_next = S_PV1;
        else if (!stat.merged) state_next = S_APPEND;
        else state_next = S_DONE;
      end
      S_PV1: begin
        cmd.op     = OP_PV1;
        state_next = S_PV2;
      end
      S_PV2: begin
        cmd.op     = OP_PV2;
        ret_next   = 1'b1;
        state_next = stat.merged ? S_FD_RD : S_DONE;
      end
      S_APPEND: begin
        cmd.op     = OP_APPEND;
        state_next = S_DONE;
      end
      S_DR_INIT: begin
        cmd.op     = OP_DROP_INIT;
        state_next = S_DR_CHK;
      end
      S_DR_CHK: begin
        if (stat.drop_more) begin
          cmd.op     = OP_DROP_RD;
          state_next = S_DR_WR;
        end else begin
          cmd.op     = OP_DROP_END;
          state_next = stat.kind ? S_DONE : S_GRANT;
        end
      end
      S_DR_WR: begin
        cmd.op     = OP_DROP_WR;
        state_next = S_DR_CHK;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = state != S_IDLE;
  assign done = state == S_DONE;

endmodule

### rtl/first_fit_block_allocator_top.sv
// First-fit boundary-tag allocator over UNITS units of UNIT_BYTES bytes.
// Pulse start while busy is low to hand in one request word; busy then stays
// high until the result word, which sits on status, granted_index and
// used_bytes_now for the single cycle that done is high. The receiver cannot
// stall, so capture the word in that cycle. Requests run one at a time, and
// the time per request follows the free list walk in the controller: an
// allocate first works out the unit count, then reads and compares list
// entries in order, and moves the later entries up when an exact fit leaves
// the list; a free searches the list up to two times, and moves the later
// entries up when a right neighbor entry is dropped.
`include "first_fit_block_allocator_top_assert.svh"
module first_fit_block_allocator_top import ffba_pkg::*; #(
  parameter int UNITS      = 256,
  parameter int UNIT_BYTES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              kind,
  input  logic [SIZE_W-1:0] size_bytes,
  input  logic [IDX_W-1:0]  block_index,
  output logic              done,
  output logic [STAT_W-1:0] status,
  output logic [IDX_W-1:0]  granted_index,
  output logic [USED_W-1:0] used_bytes_now
);

  cmd_t  cmd;
  stat_t stat;

  ffba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  ffba_datapath #(
    .UNITS      (UNITS),
    .UNIT_BYTES (UNIT_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .kind           (kind),
    .size_bytes     (size_bytes),
    .block_index    (block_index),
    .cmd            (cmd),
    .stat           (stat),
    .status         (status),
    .granted_index  (granted_index),
    .used_bytes_now (used_bytes_now)
  );

  // Checks
  `FFBA_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accepted word did not raise busy")
  `FFBA_ASSERT_NEXT(a_done_idle, clk, rst, done, !busy, "block not idle after result")
  `FFBA_ASSERT_IMPLY(a_done_busy, clk, rst, done, busy, "result while idle")
  `FFBA_ASSERT_IMPLY(a_fail_nogrant, clk, rst, done && status != ST_OK, granted_index == '0, "grant on failed request")

endmodule
